### sv/psel_pkg.sv
// psel_pkg: shared types and constants for the press count selector.
// Holds the phase encoding, register indexes, widths, reset values, counter limits and the result type.
// No dependencies.
`default_nettype none

package psel_pkg;

    // Field and register widths
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned RUN_W    = 8;
    localparam int unsigned IDLE_W   = 10;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRESSES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS   = 3'd4;

    // Register reset values
    localparam logic [COUNT_W-1:0] MAX_PRESSES_RST   = 4'd4;
    localparam logic [RUN_W-1:0]   PRESS_TICKS_RST   = 8'd4;
    localparam logic [RUN_W-1:0]   RELEASE_TICKS_RST = 8'd4;
    localparam logic [IDLE_W-1:0]  LOCK_TICKS_RST    = 10'd120;
    localparam logic [RUN_W-1:0]   PULSE_TICKS_RST   = 8'd8;

    // Saturation limits of the run counters
    localparam logic [RUN_W-1:0]  RUN_MAX  = '1;
    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_PRESS   = 2'd1,
        PH_PULSE   = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    // One result item
    typedef struct packed {
        logic               led_on;
        logic               done_res;
        logic [COUNT_W-1:0] choice;
        logic [COUNT_W-1:0] presses_so_far;
    } result_t;

endpackage

`default_nettype wire

### sv/press_count_selector.sv
// Press count selector: one request is one key sample tick. A request is
// taken in each cycle in which in_stall is low; its result is computed in
// that same cycle from the phase and run counters; the state update is a
// single registered step, so the rate is one tick per clock while in_stall
// is low. Results leave through a two-entry output buffer (output register
// plus skid register), so the input keeps flowing while one result waits;
// in_stall rises only when both entries are full. A result appears at the
// output in the next cycle when the output register is free, else later.
// Configuration writes take effect at the next clock edge; write them only
// while the block is idle.
// press_count_selector: top level, debounced multi-press counter.
// Depends on psel_pkg.
`default_nettype none

module press_count_selector
    import psel_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Input channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  key_down,
    // Output channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       led_on,
    output logic                       done_res,
    output logic [COUNT_W-1:0]         choice,
    output logic [COUNT_W-1:0]         presses_so_far
);

    // Configuration registers
    logic [COUNT_W-1:0] max_presses_reg;
    logic [RUN_W-1:0]   press_ticks_reg;
    logic [RUN_W-1:0]   release_ticks_reg;
    logic [IDLE_W-1:0]  lock_ticks_reg;
    logic [RUN_W-1:0]   pulse_ticks_reg;

    // Block state
    phase_t             phase_reg,       phase_next;
    logic [COUNT_W-1:0] press_total_reg, press_total_next;
    logic [RUN_W-1:0]   down_run_reg,    down_run_next;
    logic [RUN_W-1:0]   up_run_reg,      up_run_next;
    logic [IDLE_W-1:0]  idle_run_reg,    idle_run_next;
    logic [RUN_W-1:0]   pulse_left_reg,  pulse_left_next;

    // Output buffer
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t res_next;

    logic in_acc;
    logic out_take;

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_presses_reg   <= MAX_PRESSES_RST;
            press_ticks_reg   <= PRESS_TICKS_RST;
            release_ticks_reg <= RELEASE_TICKS_RST;
            lock_ticks_reg    <= LOCK_TICKS_RST;
            pulse_ticks_reg   <= PULSE_TICKS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAX_PRESSES:   max_presses_reg   <= cfg_data[COUNT_W-1:0];
                CFG_PRESS_TICKS:   press_ticks_reg   <= cfg_data[RUN_W-1:0];
                CFG_RELEASE_TICKS: release_ticks_reg <= cfg_data[RUN_W-1:0];
                CFG_LOCK_TICKS:    lock_ticks_reg    <= cfg_data[IDLE_W-1:0];
                CFG_PULSE_TICKS:   pulse_ticks_reg   <= cfg_data[RUN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Compute next state and the result of one tick
    always_comb
    begin
        logic accept;
        phase_next       = phase_reg;
        press_total_next = press_total_reg;
        down_run_next    = down_run_reg;
        up_run_next      = up_run_reg;
        idle_run_next    = idle_run_reg;
        pulse_left_next  = pulse_left_reg;
        accept           = 1'b0;
        res_next         = '0;

        case (phase_reg)
            PH_WAIT:
            begin
                if (key_down)
                begin
                    down_run_next = RUN_W'(1);
                    if (down_run_next >= press_ticks_reg)
                        accept = 1'b1;
                    else
                        phase_next = PH_PRESS;
                end
                else if (press_total_reg != '0)
                begin
                    if (idle_run_reg != IDLE_MAX)
                        idle_run_next = idle_run_reg + IDLE_W'(1);
                    if (idle_run_next >= lock_ticks_reg)
                    begin
                        res_next.done_res = 1'b1;
                        res_next.choice   = press_total_reg;
                        press_total_next  = '0;
                        idle_run_next     = '0;
                    end
                end
            end
            PH_PRESS:
            begin
                if (key_down)
                begin
                    if (down_run_reg != RUN_MAX)
                        down_run_next = down_run_reg + RUN_W'(1);
                end
                else
                begin
                    down_run_next = '0;
                end
                if (down_run_next >= press_ticks_reg)
                    accept = 1'b1;
            end
            PH_PULSE:
            begin
                res_next.led_on = 1'b1;
                if (pulse_left_reg != '0)
                    pulse_left_next = pulse_left_reg - RUN_W'(1);
                if (pulse_left_next == '0)
                begin
                    up_run_next = '0;
                    phase_next  = PH_RELEASE;
                end
            end
            default:
            begin
                if (!key_down)
                begin
                    if (up_run_reg != RUN_MAX)
                        up_run_next = up_run_reg + RUN_W'(1);
                end
                else
                begin
                    up_run_next = '0;
                end
                if (up_run_next >= release_ticks_reg)
                begin
                    up_run_next   = '0;
                    down_run_next = '0;
                    idle_run_next = '0;
                    phase_next    = PH_WAIT;
                end
            end
        endcase

        // Take an accepted press: below the press limit, count it and start the LED pulse if pulse ticks are nonzero
        if (accept)
        begin
            down_run_next = '0;
            up_run_next   = '0;
            phase_next    = PH_RELEASE;
            if (press_total_reg < max_presses_reg)
            begin
                press_total_next = press_total_reg + COUNT_W'(1);
                if (pulse_ticks_reg != '0)
                begin
                    pulse_left_next = pulse_ticks_reg;
                    phase_next      = PH_PULSE;
                end
            end
        end

        res_next.presses_so_far = press_total_next;
    end

    // Advance state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT;
            press_total_reg <= '0;
            down_run_reg    <= '0;
            up_run_reg      <= '0;
            idle_run_reg    <= '0;
            pulse_left_reg  <= '0;
        end
        else if (in_acc)
        begin
            phase_reg       <= phase_next;
            press_total_reg <= press_total_next;
            down_run_reg    <= down_run_next;
            up_run_reg      <= up_run_next;
            idle_run_reg    <= idle_run_next;
            pulse_left_reg  <= pulse_left_next;
        end
    end

    // Hold results in the output and skid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_acc)
        begin
            if (!out_valid_reg || out_take)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Move payload into the buffer
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (in_acc)
        begin
            if (!out_valid_reg || out_take)
                out_reg <= res_next;
            else
                skid_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign led_on         = out_reg.led_on;
    assign done_res       = out_reg.done_res;
    assign choice         = out_reg.choice;
    assign presses_so_far = out_reg.presses_so_far;

`ifndef SYNTH
    // Skid entry is only filled behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register valid while output register empty");

    // A lock always reports a nonzero count
    a_done_choice: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.done_res) |-> (out_reg.choice != '0))
        else $error("lock reported with zero choice");

    // Choice is zero on ticks without a lock
    a_choice_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.done_res) |-> (out_reg.choice == '0))
        else $error("choice nonzero without lock");

    // The pulse phase always has ticks left
    a_pulse_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PULSE) |-> (pulse_left_reg != '0))
        else $error("pulse phase with no ticks left");

    // A lock clears the count of the following tick
    a_lock_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && res_next.done_res) |=> (press_total_reg == '0))
        else $error("count not cleared after lock");
`endif

endmodule

`default_nettype wire
